// ===== rtl/csrela_pkg.sv =====
`default_nettype none
package csrela_pkg;

  localparam int DEF_MAX_ROWS     = 1024;
  localparam int DEF_MAX_COLUMNS  = 1024;
  localparam int DEF_MAX_NONZEROS = 4096;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [1:0] REQ_WR_PTR  = 2'd0;
  localparam logic [1:0] REQ_WR_SLOT = 2'd1;
  localparam logic [1:0] REQ_ADD     = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic [1:0] CFG_SYMMETRIC = 2'd0;
  localparam logic [1:0] CFG_ROWS      = 2'd1;
  localparam logic [1:0] CFG_COLUMNS   = 2'd2;

  localparam logic [10:0] ROWS_RESET    = 11'd1024;
  localparam logic [10:0] COLUMNS_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               reject;
    logic [10:0]        row;
    logic [9:0]         column;
    logic [12:0]        slot;
    logic signed [63:0] value;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [11:0]        slot_index;
    logic signed [63:0] read_value;
    logic [1:0]         status;
  } result_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_add = s;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/csrela_ram.sv =====
`default_nettype none
module csrela_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/csrela_fifo.sv =====
`default_nettype none
module csrela_fifo
  import csrela_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t din,
  output logic        full,
  input  wire logic   pop,
  output entry_t      dout,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csrela_front.sv =====
`default_nettype none
module csrela_front
  import csrela_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
  parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [10:0]        cfg_data,
  input  wire logic [1:0]         req_type,
  input  wire logic [10:0]        row,
  input  wire logic [9:0]         column,
  input  wire logic [12:0]        slot,
  input  wire logic signed [63:0] value,
  output entry_t                  entry
);

  logic        symmetric_mode;
  logic [10:0] rows_in_use;
  logic [10:0] columns_in_use;

  logic        swap;
  logic [10:0] eff_row;
  logic [10:0] eff_col;
  logic [31:0] rbound;
  logic [31:0] cbound;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symmetric_mode <= 1'b0;
      rows_in_use    <= ROWS_RESET;
      columns_in_use <= COLUMNS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYMMETRIC: symmetric_mode <= cfg_data[0];
        CFG_ROWS:      rows_in_use    <= cfg_data;
        CFG_COLUMNS:   columns_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // lookups in symmetric mode go to the upper triangle
  assign swap    = symmetric_mode && (row > {1'b0, column});
  assign eff_row = swap ? {1'b0, column} : row;
  assign eff_col = swap ? row : {1'b0, column};
  assign rbound  = (32'(rows_in_use) < 32'(MAX_ROWS)) ? 32'(rows_in_use) : 32'(MAX_ROWS);
  assign cbound  = (32'(columns_in_use) < 32'(MAX_COLUMNS)) ?
                   32'(columns_in_use) : 32'(MAX_COLUMNS);

  always_comb begin
    entry.req_type = req_type;
    entry.row      = row;
    entry.column   = column;
    entry.slot     = slot;
    entry.value    = value;
    entry.reject   = 1'b0;
    case (req_type)
      REQ_WR_PTR: begin
        entry.reject = (32'(row) > 32'(MAX_ROWS)) || (32'(slot) > 32'(MAX_NONZEROS));
      end
      REQ_WR_SLOT: begin
        entry.reject = (32'(slot) >= 32'(MAX_NONZEROS));
      end
      default: begin
        entry.row    = eff_row;
        entry.column = eff_col[9:0];
        entry.reject = (32'(eff_row) >= rbound) || (32'(eff_col) >= cbound);
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/csrela_back.sv =====
`default_nettype none
module csrela_back
  import csrela_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  output result_t     out_item,
  input  wire logic   pop
);

  localparam int RAW = $clog2(MAX_ROWS + 1);
  localparam int NAW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int PW  = $clog2(MAX_NONZEROS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD_LO  = 3'd2;
  localparam logic [2:0] S_RD_HI  = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_CHECK  = 3'd6;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [RAW-1:0] clr_addr;
  entry_t         cur;
  logic [PW-1:0]  lo;
  logic [PW-1:0]  lo_next;
  logic [PW-1:0]  hi;
  logic [PW-1:0]  hi_next;
  logic [PW-1:0]  endp;
  logic [PW-1:0]  mid;
  logic [PW-1:0]  ptr_clamped;

  logic           rs_we;
  logic [RAW-1:0] rs_waddr;
  logic [12:0]    rs_wdata;
  logic [RAW-1:0] rs_raddr;
  logic [12:0]    rs_rdata;

  logic           ec_we;
  logic [NAW-1:0] ec_waddr;
  logic [NAW-1:0] ec_raddr;
  logic [9:0]     ec_rdata;

  logic           ev_we;
  logic [NAW-1:0] ev_waddr;
  logic [63:0]    ev_wdata;
  logic [63:0]    ev_rdata;
  logic [63:0]    sum;

  logic           res_load;
  result_t        res;
  logic           take;

  assign clearing = (state == S_CLEAR);
  assign take     = (state == S_IDLE) && !q_empty && (!out_valid || pop);
  assign q_pop    = take;
  assign mid      = lo + ((hi - lo) >> 1);
  assign sum      = sat_add(ev_rdata, cur.value);
  assign ptr_clamped = (32'(rs_rdata) > 32'(MAX_NONZEROS)) ?
                       PW'(MAX_NONZEROS) : PW'(rs_rdata);

  csrela_ram #(.WIDTH(13), .DEPTH(MAX_ROWS + 1)) u_row_start (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  csrela_ram #(.WIDTH(10), .DEPTH(MAX_NONZEROS)) u_entry_column (
    .clk(clk), .we(ec_we), .waddr(ec_waddr), .wdata(cur.column),
    .raddr(ec_raddr), .rdata(ec_rdata)
  );

  csrela_ram #(.WIDTH(64), .DEPTH(MAX_NONZEROS)) u_entry_value (
    .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
    .raddr(ec_raddr), .rdata(ev_rdata)
  );

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    rs_we      = 1'b0;
    rs_waddr   = clr_addr;
    rs_wdata   = '0;
    rs_raddr   = RAW'(q_head.row);
    ec_we      = 1'b0;
    ec_waddr   = NAW'(cur.slot);
    ec_raddr   = NAW'(mid);
    ev_we      = 1'b0;
    ev_waddr   = NAW'(cur.slot);
    ev_wdata   = cur.value;
    res_load   = 1'b0;
    res        = '{found: 1'b0, slot_index: '0, read_value: '0, status: ST_OK};
    case (state)
      S_CLEAR: begin
        rs_we = 1'b1;
        if (clr_addr == RAW'(MAX_ROWS)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        state_next = take ? S_RD_LO : S_IDLE;
      end
      S_RD_LO: begin
        // pointer writes, slot writes and rejected items finish here, lookups read row+1
        rs_raddr = RAW'(cur.row) + 1'b1;
        lo_next  = ptr_clamped;
        if (cur.reject) begin
          res.status = ST_RANGE;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else if (cur.req_type == REQ_WR_PTR) begin
          rs_we      = 1'b1;
          rs_waddr   = RAW'(cur.row);
          rs_wdata   = cur.slot;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else if (cur.req_type == REQ_WR_SLOT) begin
          ec_we          = 1'b1;
          ev_we          = 1'b1;
          res.slot_index = cur.slot[11:0];
          res.read_value = cur.value;
          res_load       = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_RD_HI;
        end
      end
      S_RD_HI: begin
        hi_next = ptr_clamped;
        if (ptr_clamped <= lo) begin
          res.status = ST_ABSENT;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo < hi) begin
          state_next = S_CMP;
        end else if (lo >= endp) begin
          res.status = ST_ABSENT;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          ec_raddr   = NAW'(lo);
          state_next = S_CHECK;
        end
      end
      S_CMP: begin
        ec_raddr = NAW'(mid);
        if (ec_rdata < cur.column) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end
      S_CHECK: begin
        ec_raddr   = NAW'(lo);
        res_load   = 1'b1;
        state_next = S_IDLE;
        if (ec_rdata != cur.column) begin
          res.status = ST_ABSENT;
        end else begin
          res.found      = 1'b1;
          res.slot_index = 12'(lo);
          if (cur.req_type == REQ_ADD) begin
            ev_we          = 1'b1;
            ev_waddr       = NAW'(lo);
            ev_wdata       = sum;
            res.read_value = sum;
          end else begin
            res.read_value = ev_rdata;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_head;
    end
    if (state == S_RD_HI) begin
      endp <= ptr_clamped;
    end
    lo <= lo_next;
    hi <= hi_next;
    if (res_load) begin
      out_item <= res;
    end
  end

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid || $past(pop))
    else $error("result overwrites a waiting item");

  a_value_write: assert property (@(posedge clk) disable iff (rst)
    (ev_we && state == S_CHECK) |-> (cur.req_type == REQ_ADD && ec_rdata == cur.column))
    else $error("value written without a matching add");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop && !res_load)
    else $error("item taken during row pointer clear");

endmodule
`default_nettype wire

// ===== rtl/csr_element_lookup_accumulate.sv =====
// Flow: pointer and slot writes finish in S_RD_LO after acceptance; add and read go on
// through S_RD_HI and a binary search over the row's slots, alternating S_SEARCH and S_CMP
// through the column memory's registered read, then S_CHECK.
// Out-of-range items return from S_RD_LO, lookups in an empty row from S_RD_HI.
// Throughput: one item in flight in the back end; a 4-entry queue takes items meanwhile.
// Reset: synchronous; afterwards the row pointer memory's MAX_ROWS+1 entries (1025 by default)
// are cleared while full stays high.
`default_nettype none
module csr_element_lookup_accumulate
  import csrela_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
  parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [10:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         req_type,
  input  wire logic [10:0]        row,
  input  wire logic [9:0]         column,
  input  wire logic [12:0]        slot,
  input  wire logic signed [63:0] value,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    found,
  output logic [11:0]             slot_index,
  output logic signed [63:0]      read_value,
  output logic [1:0]              status
);

  entry_t  entry;
  entry_t  q_head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    clearing;
  logic    out_valid;
  result_t out_item;

  assign full       = q_full || clearing;
  assign empty      = !out_valid;
  assign found      = out_item.found;
  assign slot_index = out_item.slot_index;
  assign read_value = out_item.read_value;
  assign status     = out_item.status;

  csrela_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .MAX_NONZEROS(MAX_NONZEROS)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_type(req_type), .row(row), .column(column), .slot(slot), .value(value),
    .entry(entry)
  );

  csrela_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push && !full), .din(entry), .full(q_full),
    .pop(q_pop), .dout(q_head), .empty(q_empty)
  );

  csrela_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out_item(out_item),
    .pop(pop && out_valid)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
  import csrela_pkg::*;

  localparam int NROWS = 1024;
  localparam int NCOLS = 1024;
  localparam int NSLOTS = 4096;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SYMMETRIC;
  logic [10:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] req_type = REQ_READ;
  logic [10:0] row = '0;
  logic [9:0] column = '0;
  logic [12:0] slot = '0;
  logic signed [63:0] value = '0;
  logic empty;
  logic pop = 1'b0;
  logic found;
  logic [11:0] slot_index;
  logic signed [63:0] read_value;
  logic [1:0] status;

  // mirror of the element store
  logic [12:0] row_ptr_m [0:NROWS];
  logic [9:0] col_m [0:NSLOTS-1];
  logic [63:0] val_m [0:NSLOTS-1];
  bit written [0:NSLOTS-1];
  logic [10:0] slot_row [0:NSLOTS-1];
  logic sym_m;
  logic [10:0] rows_m;
  logic [10:0] cols_m;
  int loaded;

  result_t pending_q[$];
  int errors = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  csr_element_lookup_accumulate DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .req_type(req_type), .row(row), .column(column), .slot(slot), .value(value),
    .empty(empty), .pop(pop),
    .found(found), .slot_index(slot_index), .read_value(read_value), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t apply_request(logic [1:0] kind, logic [10:0] r, logic [9:0] c,
                                            logic [12:0] s, logic [63:0] v);
    result_t res;
    int rr, cc, rb, cb, lo, hi, e, mid, t;
    logic [64:0] sum;
    res = '0;
    case (kind)
      REQ_WR_PTR: begin
        if (r > NROWS || s > NSLOTS) res.status = ST_RANGE;
        else row_ptr_m[r] = s;
      end
      REQ_WR_SLOT: begin
        if (s >= NSLOTS) res.status = ST_RANGE;
        else begin
          col_m[s] = c;
          val_m[s] = v;
          written[s] = 1'b1;
          res.slot_index = s[11:0];
          res.read_value = v;
        end
      end
      default: begin
        rr = int'(r);
        cc = int'(c);
        if (sym_m && rr > cc) begin
          t = rr; rr = cc; cc = t;
        end
        rb = rows_m < NROWS ? rows_m : NROWS;
        cb = cols_m < NCOLS ? cols_m : NCOLS;
        if (rr >= rb || cc >= cb) begin
          res.status = ST_RANGE;
          return res;
        end
        lo = row_ptr_m[rr] > NSLOTS ? NSLOTS : row_ptr_m[rr];
        e = row_ptr_m[rr+1] > NSLOTS ? NSLOTS : row_ptr_m[rr+1];
        hi = e;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (col_m[mid] < cc) lo = mid + 1;
          else hi = mid;
        end
        if (lo >= e || col_m[lo] != cc) begin
          res.status = ST_ABSENT;
          return res;
        end
        if (kind == REQ_ADD) begin
          sum = {val_m[lo][63], val_m[lo]} + {v[63], v};
          // clamp when the sign bit and the guard bit disagree
          if (sum[64] != sum[63]) val_m[lo] = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          else val_m[lo] = sum[63:0];
        end
        res.found = 1'b1;
        res.slot_index = lo[11:0];
        res.read_value = val_m[lo];
        res.status = ST_OK;
      end
    endcase
    return res;
  endfunction

  // true when the row's extent is empty or covers only written slots
  function automatic bit extent_safe(int r);
    int lo, e;
    lo = row_ptr_m[r] > NSLOTS ? NSLOTS : row_ptr_m[r];
    e = row_ptr_m[r+1] > NSLOTS ? NSLOTS : row_ptr_m[r+1];
    for (int i = lo; i < e; i++) if (!written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit pointer_write_safe(int r, logic [12:0] v);
    logic [12:0] old;
    bit ok;
    if (r > NROWS || v > NSLOTS) return 1'b1;
    old = row_ptr_m[r];
    row_ptr_m[r] = v;
    ok = (r == 0 || extent_safe(r - 1)) && (r == NROWS || extent_safe(r));
    row_ptr_m[r] = old;
    return ok;
  endfunction

  always @(posedge clk) begin
    pop <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
          errors++;
        end
        if (read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, read_value);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("csr_element_lookup_accumulate regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [10:0] r, logic [9:0] c, logic [12:0] s,
                           logic [63:0] v);
    if (!steady && $urandom_range(99) < 16) begin
      if (push) push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    if (!push) push <= 1'b1;
    req_type <= kind;
    row <= r;
    column <= c;
    slot <= s;
    value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_q.push_back(apply_request(kind, r, c, s, v));
  endtask

  task automatic drain();
    if (push) push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SYMMETRIC: sym_m = data[0];
      CFG_ROWS: rows_m = data;
      default: cols_m = data;
    endcase
  endtask

  // load eight short rows with sorted columns, plus a single entry in the last row
  task automatic test_load_matrix();
    int first [0:8];
    int k, c;
    loaded = 0;
    for (int r = 0; r < 8; r++) begin
      first[r] = loaded;
      k = (r == 0) ? 4 : $urandom_range(0, 4);
      c = (r == 0) ? 0 : $urandom_range(0, 3);
      for (int j = 0; j < k; j++) begin
        slot_row[loaded] = 11'(r);
        send_item(REQ_WR_SLOT, 11'(r), 10'(c), 13'(loaded), {$urandom, $urandom});
        loaded++;
        c += $urandom_range(2, 250);
      end
    end
    first[8] = loaded;
    for (int r = 0; r <= 8; r++) send_item(REQ_WR_PTR, 11'(r), 10'd0, 13'(first[r]), '0);
    slot_row[loaded] = 11'd1023;
    send_item(REQ_WR_SLOT, 11'd1023, 10'd1023, 13'(loaded), 64'h7FFF_FFFF_0000_0000);
    send_item(REQ_WR_PTR, 11'd1023, 10'd0, 13'(loaded), '0);
    send_item(REQ_WR_PTR, 11'd1024, 10'd0, 13'(loaded + 1), '0);
    loaded++;
  endtask

  task automatic test_directed();
    // range errors on writes
    send_item(REQ_WR_PTR, 11'd2047, 10'd0, 13'd5, '0);
    send_item(REQ_WR_PTR, 11'd3, 10'd0, 13'd8191, '1);
    send_item(REQ_WR_PTR, 11'd12, 10'd0, 13'd4097, '0);
    send_item(REQ_WR_SLOT, 11'd0, 10'd1023, 13'd4096, '1);
    send_item(REQ_WR_SLOT, 11'd0, 10'd5, 13'd8191, '0);
    // saturation both ways on row 0 column 0
    send_item(REQ_WR_SLOT, 11'd0, 10'd0, 13'd0, 64'h7FFF_FFFF_FFFF_FFF0);
    send_item(REQ_ADD, 11'd0, 10'd0, 13'd0, 64'h0000_0000_1000_0000);
    send_item(REQ_WR_SLOT, 11'd0, 10'd0, 13'd0, 64'h8000_0000_0000_0001);
    send_item(REQ_ADD, 11'd0, 10'd0, 13'd0, 64'h8000_0000_0000_0000);
    send_item(REQ_ADD, 11'd0, 10'd0, 13'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(REQ_READ, 11'd0, 10'd0, 13'd0, '0);
    // absent: missing column, empty row, inverted extent
    send_item(REQ_READ, 11'd0, 10'd1, 13'd0, '0);
    send_item(REQ_ADD, 11'd500, 10'd7, 13'd0, 64'd1);
    send_item(REQ_READ, 11'd8, 10'd0, 13'd0, '0);
    // far corner and out-of-range rows
    send_item(REQ_ADD, 11'd1023, 10'd1023, 13'd0, 64'h0000_0001_0000_0000);
    send_item(REQ_READ, 11'd1024, 10'd0, 13'd0, '0);
    send_item(REQ_READ, 11'd2047, 10'd1023, 13'd0, '0);
  endtask

  task automatic random_items(int n);
    logic [1:0] kind;
    logic [10:0] r;
    logic [9:0] c;
    logic [12:0] s;
    logic signed [63:0] v;
    int p, t, pick;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      t = $urandom_range(0, 65535) - 32768;
      v = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'(t);
      s = 13'($urandom);
      kind = $urandom_range(1) ? REQ_ADD : REQ_READ;
      if (p < 70) begin
        pick = $urandom_range(0, loaded - 1);
        r = slot_row[pick];
        c = col_m[pick];
        if (sym_m && $urandom_range(1)) begin
          r = 11'(c);
          c = slot_row[pick][9:0];
        end
      end else if (p < 80) begin
        r = $urandom_range(3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 12));
        c = 10'($urandom);
      end else if (p < 90) begin
        kind = REQ_WR_SLOT;
        pick = $urandom_range(0, loaded - 1);
        s = $urandom_range(9) == 0 ? 13'($urandom_range(4096, 8191)) : 13'(pick);
        r = slot_row[pick];
        c = $urandom_range(1) ? 10'($urandom) : col_m[pick] + 10'($urandom_range(0, 2));
      end else begin
        kind = REQ_WR_PTR;
        r = $urandom_range(5) == 0 ? 11'($urandom) : 11'($urandom_range(0, 10));
        s = $urandom_range(5) == 0 ? 13'($urandom) : 13'($urandom_range(0, loaded + 2));
        if (!pointer_write_safe(int'(r), s)) r = 11'($urandom_range(1025, 2047));
      end
      send_item(kind, r, c, s, v);
    end
  endtask

  task automatic test_symmetric();
    write_reg(CFG_SYMMETRIC, 11'd1);
    send_item(REQ_READ, 11'd1023, 10'd0, 13'd0, '0);
    send_item(REQ_ADD, 11'd1023, 10'd1023, 13'd0, 64'd3);
    random_items(120);
    write_reg(CFG_SYMMETRIC, 11'd0);
  endtask

  task automatic test_bounds();
    write_reg(CFG_ROWS, 11'd1);
    write_reg(CFG_COLUMNS, 11'd1);
    send_item(REQ_READ, 11'd0, 10'd0, 13'd0, '0);
    send_item(REQ_READ, 11'd0, 10'd1, 13'd0, '0);
    send_item(REQ_READ, 11'd1, 10'd0, 13'd0, '0);
    random_items(60);
    write_reg(CFG_ROWS, 11'd0);
    random_items(40);
    write_reg(CFG_ROWS, 11'd2047);
    write_reg(CFG_COLUMNS, 11'd2047);
    random_items(100);
    write_reg(CFG_ROWS, 11'd5);
    write_reg(CFG_COLUMNS, 11'd700);
    write_reg(CFG_SYMMETRIC, 11'd1);
    random_items(60);
  endtask

  task automatic test_full_range();
    write_reg(CFG_SYMMETRIC, 11'd0);
    write_reg(CFG_ROWS, 11'd1024);
    write_reg(CFG_COLUMNS, 11'd1024);
    random_items(120);
    steady = 1'b1;
    random_items(120);
    steady = 1'b0;
    random_items(80);
  endtask

  initial begin
    for (int i = 0; i <= NROWS; i++) row_ptr_m[i] = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      col_m[i] = '0;
      val_m[i] = '0;
      written[i] = 1'b0;
      slot_row[i] = '0;
    end
    sym_m = 1'b0;
    rows_m = ROWS_RESET;
    cols_m = COLUMNS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_load_matrix();
    test_directed();
    test_symmetric();
    test_bounds();
    test_full_range();
    drain();
    if (errors == 0) begin
      $display("csr_element_lookup_accumulate regression: pass");
    end else begin
      $display("csr_element_lookup_accumulate regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
